// ===== rtl/rvde_pkg.sv =====
`default_nettype none
package rvde_pkg;

  typedef struct packed {
    logic        operation;
    logic [31:0] instruction_word;
    logic [31:0] instruction_address;
    logic [31:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] next_address;
    logic [31:0] memory_address;
    logic [1:0]  access_size;
    logic [31:0] store_data;
    logic        dest_write;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic [31:0] halt_value;
  } out_item_t;

  localparam logic [2:0] KIND_RETIRED   = 3'd0;
  localparam logic [2:0] KIND_LOAD_REQ  = 3'd1;
  localparam logic [2:0] KIND_STORE_REQ = 3'd2;
  localparam logic [2:0] KIND_HALT      = 3'd3;
  localparam logic [2:0] KIND_ILLEGAL   = 3'd4;
  localparam logic [2:0] KIND_LOAD_DONE = 3'd5;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
  localparam logic [31:0] WORD_MRET   = 32'h3020_0073;

  localparam logic [11:0] CSR_MTVEC   = 12'h305;
  localparam logic [11:0] CSR_MEPC    = 12'h341;
  localparam logic [11:0] CSR_MCAUSE  = 12'h342;
  localparam logic [11:0] CSR_MSTATUS = 12'h300;

  localparam logic [31:0] MSTATUS_RESET = 32'h0000_1800;
  localparam logic [31:0] CAUSE_ECALL_M = 32'd11;
  localparam logic [4:0]  REG_A0        = 5'd10;
  localparam logic [5:0]  MD_STEPS      = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MD,
    ST_FIX,
    ST_WB
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic md_step;
    logic md_fix;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic md_op;
    logic md_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/rvde_ctrl.sv =====
`default_nettype none
module rvde_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rvde_pkg::sts_t sts,
  output rvde_pkg::cmd_t     cmd
);

  rvde_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rvde_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rvde_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rvde_pkg::ST_EXEC;
      end
      rvde_pkg::ST_EXEC: begin
        state_nxt = sts.md_op ? rvde_pkg::ST_MD : rvde_pkg::ST_WB;
      end
      rvde_pkg::ST_MD: begin
        if (sts.md_done) state_nxt = rvde_pkg::ST_FIX;
      end
      rvde_pkg::ST_FIX: begin
        state_nxt = rvde_pkg::ST_WB;
      end
      rvde_pkg::ST_WB: begin
        if (!sts.out_busy) state_nxt = rvde_pkg::ST_IDLE;
      end
      default: state_nxt = rvde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      rvde_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      rvde_pkg::ST_EXEC: cmd.exec    = 1'b1;
      rvde_pkg::ST_MD:   cmd.md_step = !sts.md_done;
      rvde_pkg::ST_FIX:  cmd.md_fix  = 1'b1;
      rvde_pkg::ST_WB:   cmd.commit  = !sts.out_busy;
      default: ;
    endcase
  end

  // one transaction in flight at a time
  a_no_second_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in flight");

  a_commit_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.out_busy)
    else $error("commit while output register is held");

  a_md_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rvde_pkg::ST_MD && !sts.md_done) |=> state_r == rvde_pkg::ST_MD)
    else $error("mul/div left before finishing");

endmodule
`default_nettype wire

// ===== rtl/rvde_dp.sv =====
`default_nettype none
module rvde_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rvde_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rvde_pkg::out_item_t     out_data,
  input  wire rvde_pkg::cmd_t     cmd,
  output rvde_pkg::sts_t          sts
);

  // register file: memory plus per-entry valid bits so reset reads zero
  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid_r;
  logic [31:0] rs1_r, rs2_r;
  rvde_pkg::in_item_t item_r;

  logic [31:0] mtvec_r, mepc_r, mcause_r, mstatus_r;
  logic        pend_r, pend_signed_r;
  logic [4:0]  pend_dest_r;
  logic [1:0]  pend_size_r;

  rvde_pkg::out_item_t res_r, res;
  logic        csr_we_r, csr_we;
  logic [31:0] csr_val_r, csr_val;
  logic        ecall_r, ecall;
  logic        ld_set_r, ld_set;
  logic        ld_clr_r, ld_clr;

  logic [63:0] md_p_r;
  logic [31:0] md_d_r;
  logic [5:0]  md_cnt_r;
  logic        md_neg_r;

  rvde_pkg::out_item_t out_r;
  logic        out_valid_r;

  logic [4:0]  ra1, ra2;
  logic [31:0] w, pc, a, b, ld;
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [4:0]  rd, rdx;
  logic [11:0] csr_addr;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [31:0] v, csr_rd;
  logic        wr, illegal, md, taken;

  assign ra1 = (in_data.instruction_word == rvde_pkg::WORD_EBREAK) ? rvde_pkg::REG_A0
                                                                   : in_data.instruction_word[19:15];
  assign ra2 = in_data.instruction_word[24:20];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
      rs1_r  <= rf_valid_r[ra1] ? rf_mem[ra1] : 32'd0;
      rs2_r  <= rf_valid_r[ra2] ? rf_mem[ra2] : 32'd0;
    end
    if (cmd.commit && res_r.dest_write) begin
      rf_mem[res_r.dest_index] <= res_r.dest_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_valid_r <= '0;
    end else if (cmd.commit && res_r.dest_write) begin
      rf_valid_r[res_r.dest_index] <= 1'b1;
    end
  end

  assign w        = item_r.instruction_word;
  assign pc       = item_r.instruction_address;
  assign ld       = item_r.load_data;
  assign a        = rs1_r;
  assign b        = rs2_r;
  assign opc      = w[6:0];
  assign f3       = w[14:12];
  assign f7       = w[31:25];
  assign rd       = w[11:7];
  assign csr_addr = w[31:20];
  assign imm_i    = {{20{w[31]}}, w[31:20]};
  assign imm_s    = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b    = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j    = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
  assign imm_u    = {w[31:12], 12'd0};

  always_comb begin
    case (csr_addr)
      rvde_pkg::CSR_MTVEC:   csr_rd = mtvec_r;
      rvde_pkg::CSR_MEPC:    csr_rd = mepc_r;
      rvde_pkg::CSR_MCAUSE:  csr_rd = mcause_r;
      rvde_pkg::CSR_MSTATUS: csr_rd = mstatus_r;
      default:               csr_rd = 32'd0;
    endcase
  end

  always_comb begin
    res     = '0;
    wr      = 1'b0;
    v       = 32'd0;
    rdx     = rd;
    illegal = 1'b0;
    md      = 1'b0;
    taken   = 1'b0;
    csr_we  = 1'b0;
    csr_val = 32'd0;
    ecall   = 1'b0;
    ld_set  = 1'b0;
    ld_clr  = 1'b0;
    if (item_r.operation) begin
      res.result_kind = rvde_pkg::KIND_LOAD_DONE;
      if (pend_r) begin
        case (pend_size_r)
          2'd0:    v = pend_signed_r ? {{24{ld[7]}}, ld[7:0]} : {24'd0, ld[7:0]};
          2'd1:    v = pend_signed_r ? {{16{ld[15]}}, ld[15:0]} : {16'd0, ld[15:0]};
          default: v = ld;
        endcase
        res.access_size = pend_size_r;
        wr     = 1'b1;
        rdx    = pend_dest_r;
        ld_clr = 1'b1;
      end
    end else begin
      res.result_kind  = rvde_pkg::KIND_RETIRED;
      res.next_address = pc + 32'd4;
      case (opc)
        rvde_pkg::OPC_LUI: begin
          wr = 1'b1;
          v  = imm_u;
        end
        rvde_pkg::OPC_AUIPC: begin
          wr = 1'b1;
          v  = pc + imm_u;
        end
        rvde_pkg::OPC_JAL: begin
          wr = 1'b1;
          v  = pc + 32'd4;
          res.next_address = pc + imm_j;
        end
        rvde_pkg::OPC_JALR: begin
          if (f3 != 3'd0) begin
            illegal = 1'b1;
          end else begin
            res.next_address = (a + imm_i) & ~32'd1;
            wr = 1'b1;
            v  = pc + 32'd4;
          end
        end
        rvde_pkg::OPC_BRANCH: begin
          case (f3)
            3'd0:    taken = (a == b);
            3'd1:    taken = (a != b);
            3'd4:    taken = ($signed(a) < $signed(b));
            3'd5:    taken = !($signed(a) < $signed(b));
            3'd6:    taken = (a < b);
            3'd7:    taken = (a >= b);
            default: illegal = 1'b1;
          endcase
          if (taken) res.next_address = pc + imm_b;
        end
        rvde_pkg::OPC_LOAD: begin
          if (f3 == 3'd3 || f3 > 3'd5) begin
            illegal = 1'b1;
          end else begin
            res.result_kind    = rvde_pkg::KIND_LOAD_REQ;
            res.memory_address = a + imm_i;
            res.access_size    = f3[1:0];
            ld_set = 1'b1;
          end
        end
        rvde_pkg::OPC_STORE: begin
          if (f3 > 3'd2) begin
            illegal = 1'b1;
          end else begin
            res.result_kind    = rvde_pkg::KIND_STORE_REQ;
            res.memory_address = a + imm_s;
            res.access_size    = f3[1:0];
            res.store_data     = b;
          end
        end
        rvde_pkg::OPC_IMM: begin
          wr = 1'b1;
          case (f3)
            3'd0: v = a + imm_i;
            3'd2: v = {31'd0, $signed(a) < $signed(imm_i)};
            3'd3: v = {31'd0, a < imm_i};
            3'd4: v = a ^ imm_i;
            3'd6: v = a | imm_i;
            3'd7: v = a & imm_i;
            3'd1: begin
              if (f7 != rvde_pkg::F7_BASE) illegal = 1'b1;
              v = a << w[24:20];
            end
            default: begin
              if (f7 == rvde_pkg::F7_BASE)     v = a >> w[24:20];
              else if (f7 == rvde_pkg::F7_ALT) v = 32'($signed(a) >>> w[24:20]);
              else illegal = 1'b1;
            end
          endcase
        end
        rvde_pkg::OPC_REG: begin
          wr = 1'b1;
          if (f7 == rvde_pkg::F7_BASE) begin
            case (f3)
              3'd0:    v = a + b;
              3'd1:    v = a << b[4:0];
              3'd2:    v = {31'd0, $signed(a) < $signed(b)};
              3'd3:    v = {31'd0, a < b};
              3'd4:    v = a ^ b;
              3'd5:    v = a >> b[4:0];
              3'd6:    v = a | b;
              default: v = a & b;
            endcase
          end else if (f7 == rvde_pkg::F7_ALT) begin
            if (f3 == 3'd0)      v = a - b;
            else if (f3 == 3'd5) v = 32'($signed(a) >>> b[4:0]);
            else illegal = 1'b1;
          end else if (f7 == rvde_pkg::F7_MULDIV) begin
            // divide by zero is settled here, everything else iterates
            if (f3[2] && b == 32'd0) v = f3[1] ? a : 32'hFFFF_FFFF;
            else md = 1'b1;
          end else begin
            illegal = 1'b1;
          end
        end
        rvde_pkg::OPC_SYSTEM: begin
          if (f3 == 3'd1) begin
            wr      = 1'b1;
            v       = csr_rd;
            csr_we  = 1'b1;
            csr_val = a;
          end else if (f3 == 3'd2) begin
            wr      = 1'b1;
            v       = csr_rd;
            csr_we  = (a != 32'd0);
            csr_val = csr_rd | a;
          end else if (w == rvde_pkg::WORD_ECALL) begin
            ecall = 1'b1;
            res.next_address = mtvec_r;
          end else if (w == rvde_pkg::WORD_EBREAK) begin
            res.result_kind  = rvde_pkg::KIND_HALT;
            res.next_address = pc;
            res.halt_value   = a;
          end else if (w == rvde_pkg::WORD_MRET) begin
            res.next_address = mepc_r;
          end else begin
            illegal = 1'b1;
          end
        end
        default: illegal = 1'b1;
      endcase
      if (illegal) begin
        res = '0;
        res.result_kind  = rvde_pkg::KIND_ILLEGAL;
        res.next_address = pc;
        wr     = 1'b0;
        md     = 1'b0;
        csr_we = 1'b0;
        ecall  = 1'b0;
        ld_set = 1'b0;
      end
    end
    if (wr && rdx != 5'd0) begin
      res.dest_write = 1'b1;
      res.dest_index = rdx;
      res.dest_value = v;
    end
  end

  // iterative mul/div: shift-add multiply, restoring divide on magnitudes
  logic [31:0] abs_a, abs_b;
  logic [33:0] div_trial;
  logic [32:0] mul_sum;
  logic [63:0] mul_full;
  logic [31:0] md_res, q_fix, r_fix;

  assign abs_a     = a[31] ? (32'd0 - a) : a;
  assign abs_b     = b[31] ? (32'd0 - b) : b;
  assign mul_sum   = {1'b0, md_p_r[63:32]} + (md_p_r[0] ? {1'b0, md_d_r} : 33'd0);
  assign div_trial = {1'b0, md_p_r[63:31]} - {2'd0, md_d_r};
  assign mul_full  = md_neg_r ? (64'd0 - md_p_r) : md_p_r;
  assign q_fix     = md_neg_r ? (32'd0 - md_p_r[31:0]) : md_p_r[31:0];
  assign r_fix     = md_neg_r ? (32'd0 - md_p_r[63:32]) : md_p_r[63:32];

  always_comb begin
    if (f3[2])             md_res = f3[1] ? r_fix : q_fix;
    else if (f3 == 3'd0)   md_res = mul_full[31:0];
    else                   md_res = mul_full[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_cnt_r <= '0;
    end else if (cmd.exec && md) begin
      md_cnt_r <= '0;
    end else if (cmd.md_step) begin
      md_cnt_r <= md_cnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && md) begin
      case (f3)
        3'd1, 3'd4: begin
          md_p_r   <= {32'd0, abs_a};
          md_d_r   <= abs_b;
          md_neg_r <= a[31] ^ b[31];
        end
        3'd2: begin
          md_p_r   <= {32'd0, abs_a};
          md_d_r   <= b;
          md_neg_r <= a[31];
        end
        3'd6: begin
          md_p_r   <= {32'd0, abs_a};
          md_d_r   <= abs_b;
          md_neg_r <= a[31];
        end
        default: begin
          md_p_r   <= {32'd0, a};
          md_d_r   <= b;
          md_neg_r <= 1'b0;
        end
      endcase
    end else if (cmd.md_step) begin
      if (!f3[2]) begin
        md_p_r <= {mul_sum, md_p_r[31:1]};
      end else if (!div_trial[33]) begin
        md_p_r <= {div_trial[31:0], md_p_r[30:0], 1'b1};
      end else begin
        md_p_r <= {md_p_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r     <= res;
      csr_we_r  <= csr_we;
      csr_val_r <= csr_val;
      ecall_r   <= ecall;
      ld_set_r  <= ld_set;
      ld_clr_r  <= ld_clr;
    end else if (cmd.md_fix && res_r.dest_write) begin
      res_r.dest_value <= md_res;
    end
  end

  // architectural state updates at write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtvec_r       <= '0;
      mepc_r        <= '0;
      mcause_r      <= '0;
      mstatus_r     <= rvde_pkg::MSTATUS_RESET;
      pend_r        <= 1'b0;
      pend_dest_r   <= '0;
      pend_size_r   <= '0;
      pend_signed_r <= 1'b0;
    end else if (cmd.commit) begin
      if (csr_we_r) begin
        case (csr_addr)
          rvde_pkg::CSR_MTVEC:   mtvec_r   <= csr_val_r;
          rvde_pkg::CSR_MEPC:    mepc_r    <= csr_val_r;
          rvde_pkg::CSR_MCAUSE:  mcause_r  <= csr_val_r;
          rvde_pkg::CSR_MSTATUS: mstatus_r <= csr_val_r;
          default: ;
        endcase
      end
      if (ecall_r) begin
        mepc_r   <= pc + 32'd4;
        mcause_r <= rvde_pkg::CAUSE_ECALL_M;
      end
      if (ld_set_r) begin
        pend_r        <= 1'b1;
        pend_dest_r   <= rd;
        pend_size_r   <= f3[1:0];
        pend_signed_r <= !f3[2];
      end else if (ld_clr_r) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_r <= res_r;
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.md_op    = md;
  assign sts.md_done  = (md_cnt_r == rvde_pkg::MD_STEPS);
  assign sts.out_busy = out_valid_r && out_stall;

endmodule
`default_nettype wire

// ===== rtl/rv32im_decode_execute_unit.sv =====
`default_nettype none
// Executes one RV32IM instruction (or one load-data delivery) per input
// transaction and returns exactly one result transaction. Items are handled
// one at a time: an item is taken, its source registers are read from the
// register file memory, it is decoded and executed, and the result is
// written to the output register. The next item is accepted only once the
// current one has left write-back. MUL, MULH*, DIV* and REM* go through a
// shared shift-add / restoring divide unit that retires one bit per cycle,
// followed by a fix-up step before write-back. Division by zero is
// resolved without iterating. The next item is accepted while a result
// still waits in the output register; a stalled output holds the following
// item in write-back.
module rv32im_decode_execute_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rvde_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rvde_pkg::out_item_t      out_data
);

  rvde_pkg::cmd_t cmd;
  rvde_pkg::sts_t sts;

  rvde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rvde_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

// ===== tb/tb_rv32im_decode_execute_unit.sv =====
`timescale 1ns / 1ps
module tb_rv32im_decode_execute_unit;

  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
  localparam logic [2:0] F3_CSRRW = 3'd1, F3_CSRRS = 3'd2;
  localparam logic OP_EXEC = 1'b0, OP_LOAD_DATA = 1'b1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  rvde_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  rvde_pkg::out_item_t out_data;

  rv32im_decode_execute_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state
  logic [31:0] gpr [32];
  logic [31:0] mtvec_q, mepc_q, mcause_q, mstatus_q;
  logic        ld_pend;
  logic [4:0]  ld_rd;
  logic [1:0]  ld_size;
  logic        ld_sext;

  rvde_pkg::in_item_t  pending_items[$];
  rvde_pkg::out_item_t expected_results[$];
  int errors = 0;
  bit in_taken = 0;
  int in_gap = 0, out_gap = 0;
  int idle_cycles = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] csr_fetch(logic [11:0] n);
    case (n)
      rvde_pkg::CSR_MTVEC:   return mtvec_q;
      rvde_pkg::CSR_MEPC:    return mepc_q;
      rvde_pkg::CSR_MCAUSE:  return mcause_q;
      rvde_pkg::CSR_MSTATUS: return mstatus_q;
      default:               return 32'd0;
    endcase
  endfunction

  task automatic csr_store(logic [11:0] n, logic [31:0] v);
    case (n)
      rvde_pkg::CSR_MTVEC:   mtvec_q = v;
      rvde_pkg::CSR_MEPC:    mepc_q = v;
      rvde_pkg::CSR_MCAUSE:  mcause_q = v;
      rvde_pkg::CSR_MSTATUS: mstatus_q = v;
      default: ;
    endcase
  endtask

  task automatic reg_write(logic [4:0] rd, logic [31:0] v, inout rvde_pkg::out_item_t r);
    if (rd != 5'd0) begin
      gpr[rd] = v;
      r.dest_write = 1'b1;
      r.dest_index = rd;
      r.dest_value = v;
    end
  endtask

  function automatic logic [31:0] mul_high(logic [31:0] a, logic [31:0] b, bit sa, bit sb);
    logic [63:0] x, y, p;
    x = sa ? {{32{a[31]}}, a} : {32'd0, a};
    y = sb ? {{32{b[31]}}, b} : {32'd0, b};
    p = x * y;
    return p[63:32];
  endfunction

  function automatic logic [31:0] div_signed(logic [31:0] a, logic [31:0] b, bit want_rem);
    logic [31:0] ma, mb, q, r;
    if (b == 0) return want_rem ? a : 32'hFFFF_FFFF;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return want_rem ? 32'd0 : 32'h8000_0000;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (a[31] ^ b[31]) q = -q;
    if (a[31]) r = -r;
    return want_rem ? r : q;
  endfunction

  // computes the result of one transaction and updates the architectural state
  task automatic execute_item(rvde_pkg::in_item_t it, output rvde_pkg::out_item_t r);
    logic [31:0] w, pc, a, b, imm_i, imm_s, imm_b, imm_j, imm_u, v, old;
    logic [6:0] opc, f7;
    logic [2:0] f3;
    logic [4:0] rd, sh;
    bit taken, bad;
    r = '0;
    if (it.operation == OP_LOAD_DATA) begin
      r.result_kind = rvde_pkg::KIND_LOAD_DONE;
      if (!ld_pend) return;
      case (ld_size)
        2'd0: v = ld_sext ? {{24{it.load_data[7]}}, it.load_data[7:0]}
                          : {24'd0, it.load_data[7:0]};
        2'd1: v = ld_sext ? {{16{it.load_data[15]}}, it.load_data[15:0]}
                          : {16'd0, it.load_data[15:0]};
        default: v = it.load_data;
      endcase
      r.access_size = ld_size;
      reg_write(ld_rd, v, r);
      ld_pend = 0;
      return;
    end
    w = it.instruction_word;
    pc = it.instruction_address;
    opc = w[6:0]; f3 = w[14:12]; f7 = w[31:25]; rd = w[11:7]; sh = w[24:20];
    a = gpr[w[19:15]];
    b = gpr[w[24:20]];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    imm_u = {w[31:12], 12'd0};
    r.result_kind = rvde_pkg::KIND_RETIRED;
    r.next_address = pc + 4;
    bad = 0;
    case (opc)
      rvde_pkg::OPC_LUI: reg_write(rd, imm_u, r);
      rvde_pkg::OPC_AUIPC: reg_write(rd, pc + imm_u, r);
      rvde_pkg::OPC_JAL: begin
        reg_write(rd, pc + 4, r);
        r.next_address = pc + imm_j;
      end
      rvde_pkg::OPC_JALR: begin
        if (f3 != 0) bad = 1;
        else begin
          r.next_address = (a + imm_i) & ~32'd1;
          reg_write(rd, pc + 4, r);
        end
      end
      rvde_pkg::OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  taken = a == b;
          F3_BNE:  taken = a != b;
          F3_BLT:  taken = $signed(a) < $signed(b);
          F3_BGE:  taken = $signed(a) >= $signed(b);
          F3_BLTU: taken = a < b;
          F3_BGEU: taken = a >= b;
          default: bad = 1;
        endcase
        if (!bad && taken) r.next_address = pc + imm_b;
      end
      rvde_pkg::OPC_LOAD: begin
        if (f3 == 3 || f3 > 5) bad = 1;
        else begin
          r.result_kind = rvde_pkg::KIND_LOAD_REQ;
          r.memory_address = a + imm_i;
          r.access_size = f3[1:0];
          ld_pend = 1; ld_rd = rd; ld_size = f3[1:0]; ld_sext = f3 < 4;
        end
      end
      rvde_pkg::OPC_STORE: begin
        if (f3 > 2) bad = 1;
        else begin
          r.result_kind = rvde_pkg::KIND_STORE_REQ;
          r.memory_address = a + imm_s;
          r.access_size = f3[1:0];
          r.store_data = b;
        end
      end
      rvde_pkg::OPC_IMM: begin
        case (f3)
          3'd0: v = a + imm_i;
          3'd2: v = {31'd0, $signed(a) < $signed(imm_i)};
          3'd3: v = {31'd0, a < imm_i};
          3'd4: v = a ^ imm_i;
          3'd6: v = a | imm_i;
          3'd7: v = a & imm_i;
          3'd1: if (f7 != rvde_pkg::F7_BASE) bad = 1; else v = a << sh;
          default: begin
            if (f7 == rvde_pkg::F7_BASE) v = a >> sh;
            else if (f7 == rvde_pkg::F7_ALT) v = $signed(a) >>> sh;
            else bad = 1;
          end
        endcase
        if (!bad) reg_write(rd, v, r);
      end
      rvde_pkg::OPC_REG: begin
        if (f7 == rvde_pkg::F7_BASE) begin
          case (f3)
            3'd0: v = a + b;
            3'd1: v = a << b[4:0];
            3'd2: v = {31'd0, $signed(a) < $signed(b)};
            3'd3: v = {31'd0, a < b};
            3'd4: v = a ^ b;
            3'd5: v = a >> b[4:0];
            3'd6: v = a | b;
            default: v = a & b;
          endcase
        end else if (f7 == rvde_pkg::F7_ALT) begin
          if (f3 == 0) v = a - b;
          else if (f3 == 5) v = $signed(a) >>> b[4:0];
          else bad = 1;
        end else if (f7 == rvde_pkg::F7_MULDIV) begin
          case (f3)
            3'd0: v = a * b;
            3'd1: v = mul_high(a, b, 1, 1);
            3'd2: v = mul_high(a, b, 1, 0);
            3'd3: v = mul_high(a, b, 0, 0);
            3'd4: v = div_signed(a, b, 0);
            3'd5: v = (b == 0) ? 32'hFFFF_FFFF : a / b;
            3'd6: v = div_signed(a, b, 1);
            default: v = (b == 0) ? a : a % b;
          endcase
        end else bad = 1;
        if (!bad) reg_write(rd, v, r);
      end
      rvde_pkg::OPC_SYSTEM: begin
        if (f3 == F3_CSRRW) begin
          old = csr_fetch(w[31:20]);
          csr_store(w[31:20], a);
          reg_write(rd, old, r);
        end else if (f3 == F3_CSRRS) begin
          old = csr_fetch(w[31:20]);
          if (a != 0) csr_store(w[31:20], old | a);
          reg_write(rd, old, r);
        end else if (w == rvde_pkg::WORD_ECALL) begin
          mepc_q = pc + 4;
          mcause_q = rvde_pkg::CAUSE_ECALL_M;
          r.next_address = mtvec_q;
        end else if (w == rvde_pkg::WORD_EBREAK) begin
          r.result_kind = rvde_pkg::KIND_HALT;
          r.next_address = pc;
          r.halt_value = gpr[rvde_pkg::REG_A0];
        end else if (w == rvde_pkg::WORD_MRET) begin
          r.next_address = mepc_q;
        end else bad = 1;
      end
      default: bad = 1;
    endcase
    if (bad) begin
      r = '0;
      r.result_kind = rvde_pkg::KIND_ILLEGAL;
      r.next_address = pc;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_taken) begin
        in_taken = 1'b0;
        if (in_gap > 0) begin
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_gap = $urandom_range(0, 9) * ($urandom_range(0, 3) != 0);
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap--;
        else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          in_gap = $urandom_range(0, 9) * ($urandom_range(0, 3) != 0);
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rvde_pkg::out_item_t exp_r, got;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        idle_cycles = 0;
        in_taken = 1'b1;
        execute_item(in_data, exp_r);
        expected_results.push_back(exp_r);
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        got = out_data;
        if ($urandom_range(0, 3) != 0) out_gap = $urandom_range(0, 9);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $realtime, got);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, exp_r, got);
            $display("  kind %0d/%0d next %h/%h maddr %h/%h size %0d/%0d",
                     exp_r.result_kind, got.result_kind, exp_r.next_address,
                     got.next_address, exp_r.memory_address, got.memory_address,
                     exp_r.access_size, got.access_size);
            $display("  sdata %h/%h wr %0d/%0d rd %0d/%0d val %h/%h halt %h/%h",
                     exp_r.store_data, got.store_data, exp_r.dest_write, got.dest_write,
                     exp_r.dest_index, got.dest_index, exp_r.dest_value, got.dest_value,
                     exp_r.halt_value, got.halt_value);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_rv32im_decode_execute_unit: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic rvde_pkg::in_item_t exec_item(logic [31:0] w);
    rvde_pkg::in_item_t it;
    it.operation = OP_EXEC;
    it.instruction_word = w;
    it.instruction_address = $urandom;
    it.load_data = $urandom;
    return it;
  endfunction

  function automatic rvde_pkg::in_item_t data_item(logic [31:0] d);
    rvde_pkg::in_item_t it;
    it.operation = OP_LOAD_DATA;
    it.instruction_word = $urandom;
    it.instruction_address = $urandom;
    it.load_data = d;
    return it;
  endfunction

  function automatic logic [4:0] rand_reg();
    return ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(1, 12));
  endfunction

  function automatic logic [11:0] rand_csr_num();
    case ($urandom_range(0, 4))
      0: return rvde_pkg::CSR_MTVEC;
      1: return rvde_pkg::CSR_MEPC;
      2: return rvde_pkg::CSR_MCAUSE;
      3: return rvde_pkg::CSR_MSTATUS;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // mostly well-formed instruction with random registers and immediates
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    logic [2:0] f3;
    w = $urandom;
    w[11:7] = rand_reg();
    w[19:15] = rand_reg();
    w[24:20] = rand_reg();
    f3 = 3'($urandom_range(0, 7));
    w[14:12] = f3;
    case ($urandom_range(0, 13))
      0: w[6:0] = rvde_pkg::OPC_LUI;
      1: w[6:0] = rvde_pkg::OPC_AUIPC;
      2: w[6:0] = rvde_pkg::OPC_JAL;
      3: begin w[6:0] = rvde_pkg::OPC_JALR; w[14:12] = 3'd0; end
      4: w[6:0] = rvde_pkg::OPC_BRANCH;
      5: w[6:0] = rvde_pkg::OPC_LOAD;
      6: w[6:0] = rvde_pkg::OPC_STORE;
      7, 8: begin
        w[6:0] = rvde_pkg::OPC_IMM;
        if ($urandom_range(0, 3) != 0)
          w[31:25] = (f3 == 5 && $urandom_range(0, 1)) ? rvde_pkg::F7_ALT
                                                        : rvde_pkg::F7_BASE;
      end
      9, 10, 11: begin
        w[6:0] = rvde_pkg::OPC_REG;
        case ($urandom_range(0, 4))
          0: w[31:25] = rvde_pkg::F7_BASE;
          1: w[31:25] = rvde_pkg::F7_ALT;
          4: ;
          default: w[31:25] = rvde_pkg::F7_MULDIV;
        endcase
      end
      12: begin
        w[6:0] = rvde_pkg::OPC_SYSTEM;
        w[14:12] = $urandom_range(0, 1) ? F3_CSRRW : F3_CSRRS;
        w[31:20] = rand_csr_num();
      end
      default: begin
        case ($urandom_range(0, 3))
          0: w = rvde_pkg::WORD_ECALL;
          1: w = rvde_pkg::WORD_EBREAK;
          2: w = rvde_pkg::WORD_MRET;
          default: ;
        endcase
      end
    endcase
    return w;
  endfunction

  // seed registers x1..x12 with chosen values via lui + addi
  task automatic load_reg(logic [4:0] rd, logic [31:0] v);
    logic [31:0] hi;
    hi = v + {20'd0, v[11], 11'd0};
    pending_items.push_back(exec_item({hi[31:12], rd, rvde_pkg::OPC_LUI}));
    pending_items.push_back(exec_item({v[11:0], rd, 3'd0, rd, rvde_pkg::OPC_IMM}));
  endtask

  initial begin
    logic [31:0] w;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    mtvec_q = 0; mepc_q = 0; mcause_q = 0; mstatus_q = rvde_pkg::MSTATUS_RESET;
    ld_pend = 0; ld_rd = 0; ld_size = 0; ld_sext = 0;

    // directed part
    pending_items.push_back(data_item(32'hFFFF_FFFF));
    load_reg(5'd1, 32'h8000_0000);
    load_reg(5'd2, 32'hFFFF_FFFF);
    pending_items.push_back(exec_item({rvde_pkg::F7_MULDIV, 5'd2, 5'd1, 3'd4, 5'd3,
                                       rvde_pkg::OPC_REG}));
    pending_items.push_back(exec_item({rvde_pkg::F7_MULDIV, 5'd2, 5'd1, 3'd6, 5'd3,
                                       rvde_pkg::OPC_REG}));
    pending_items.push_back(exec_item({rvde_pkg::F7_MULDIV, 5'd0, 5'd1, 3'd4, 5'd3,
                                       rvde_pkg::OPC_REG}));
    pending_items.push_back(exec_item({rvde_pkg::F7_MULDIV, 5'd0, 5'd1, 3'd5, 5'd3,
                                       rvde_pkg::OPC_REG}));
    pending_items.push_back(exec_item({rvde_pkg::F7_MULDIV, 5'd0, 5'd1, 3'd6, 5'd3,
                                       rvde_pkg::OPC_REG}));
    pending_items.push_back(exec_item({rvde_pkg::F7_MULDIV, 5'd0, 5'd1, 3'd7, 5'd3,
                                       rvde_pkg::OPC_REG}));
    pending_items.push_back(exec_item({rvde_pkg::F7_ALT, 5'd31, 5'd1, 3'd5, 5'd4,
                                       rvde_pkg::OPC_IMM}));
    pending_items.push_back(exec_item({12'h305, 5'd2, F3_CSRRW, 5'd5, rvde_pkg::OPC_SYSTEM}));
    pending_items.push_back(exec_item({12'h300, 5'd0, F3_CSRRS, 5'd6, rvde_pkg::OPC_SYSTEM}));
    pending_items.push_back(exec_item({12'h7C0, 5'd2, F3_CSRRW, 5'd6, rvde_pkg::OPC_SYSTEM}));
    pending_items.push_back(exec_item(rvde_pkg::WORD_ECALL));
    pending_items.push_back(exec_item(rvde_pkg::WORD_MRET));
    pending_items.push_back(exec_item({12'h342, 5'd0, F3_CSRRS, 5'd7, rvde_pkg::OPC_SYSTEM}));
    pending_items.push_back(exec_item(rvde_pkg::WORD_EBREAK));
    pending_items.push_back(exec_item({12'd0, 5'd1, 3'd4, 5'd8, rvde_pkg::OPC_LOAD}));
    pending_items.push_back(exec_item({12'hFFF, 5'd1, 3'd1, 5'd9, rvde_pkg::OPC_LOAD}));
    pending_items.push_back(data_item(32'hFFFF_8080));
    pending_items.push_back(exec_item({7'h7F, 5'd2, 5'd1, 3'd2, 5'h1F, rvde_pkg::OPC_STORE}));
    pending_items.push_back(exec_item(32'hFFFF_FFFF));
    pending_items.push_back(exec_item(32'h0000_0000));

    // random part: mostly well-formed, some load sequences, some noise
    for (int n = 0; n < 1470; n++) begin
      case ($urandom_range(0, 19))
        0: pending_items.push_back(exec_item($urandom));
        1: pending_items.push_back(data_item($urandom));
        2, 3: begin
          w = $urandom;
          w[6:0] = rvde_pkg::OPC_LOAD;
          w[11:7] = rand_reg();
          w[19:15] = rand_reg();
          w[14:12] = 3'($urandom_range(0, 2) + 4 * $urandom_range(0, 1));
          if (w[14:12] == 3'd6) w[14:12] = 3'd2;
          pending_items.push_back(exec_item(w));
          if ($urandom_range(0, 3) == 0) pending_items.push_back(exec_item(rand_instr()));
          pending_items.push_back(data_item(rand_value()));
        end
        4: load_reg(5'($urandom_range(1, 12)), rand_value());
        default: pending_items.push_back(exec_item(rand_instr()));
      endcase
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (80) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("tb_rv32im_decode_execute_unit: done, clean");
    else
      $display("tb_rv32im_decode_execute_unit: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rvde_pkg.sv
rtl/rvde_ctrl.sv
rtl/rvde_dp.sv
rtl/rv32im_decode_execute_unit.sv
tb/tb_rv32im_decode_execute_unit.sv
